[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/bth_pkg.sv]
package bth_pkg;

   localparam int BLOCK_NUMBER_W = 31;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_FIND    = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_REPLACE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_PRESENT   = 2'd3
   } status_type;

   // queued request as the back end sees it
   typedef struct packed {
      logic                      valid;
      op_type                    op;
      logic [BLOCK_NUMBER_W-1:0] key;
      logic                      temperature;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_stat_type;

endpackage

[hw/rtl/bth_front.sv]
module bth_front #(
   parameter int KEY_BITS = 31
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [1:0]                         req_operation,
   input  logic [bth_pkg::BLOCK_NUMBER_W-1:0] req_block_number,
   input  logic                               req_temperature,
   input  bth_pkg::back_stat_type             back_stat,
   output logic                               busy,
   output bth_pkg::cmd_type                   head
);
   import bth_pkg::*;

   localparam logic [BLOCK_NUMBER_W-1:0] KEY_MASK = (KEY_BITS >= BLOCK_NUMBER_W) ? '1 :
      BLOCK_NUMBER_W'((64'(1) << KEY_BITS) - 64'(1));

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;
   cmd_type             new_cmd;

   assign busy = back_stat.clearing || (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push = start && !busy;
   assign pop  = back_stat.pop;

   always_comb begin
      new_cmd             = '0;
      new_cmd.valid       = 1'b1;
      new_cmd.op          = op_type'(req_operation);
      new_cmd.key         = req_block_number & KEY_MASK;
      new_cmd.temperature = req_temperature;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   always_comb begin
      head       = q_ff[rd_ptr_ff];
      head.valid = (count_ff != '0);
   end

endmodule

[hw/rtl/bth_back.sv]
module bth_back #(
   parameter int BUCKETS  = 512,
   parameter int WAYS     = 4,
   parameter int KEY_BITS = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bth_pkg::cmd_type       head,
   output bth_pkg::back_stat_type back_stat,
   output logic                   rsp_valid,
   output logic                   rsp_found,
   output logic                   rsp_temperature_out,
   output logic [1:0]             rsp_status
);
   import bth_pkg::*;

   localparam int IDX_W = $clog2(BUCKETS);
   localparam int KW    = (KEY_BITS < BLOCK_NUMBER_W) ? KEY_BITS : BLOCK_NUMBER_W;
   localparam int EW    = KW + 2;
   localparam int ROW_W = WAYS * EW;

   typedef enum logic [1:0] {S_CLEAR, S_READ, S_EXEC} state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] clr_ff;
   logic             rsp_valid_ff;
   logic             rsp_found_ff;
   logic             rsp_temp_ff;
   status_type       rsp_status_ff;

   logic [ROW_W-1:0] mem [BUCKETS];
   logic [ROW_W-1:0] rd_row_ff;
   logic [IDX_W-1:0] bucket;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ROW_W-1:0] wr_data;

   logic [WAYS-1:0]  vld, mk, hit, free, first_hit, first_free;
   logic [KW-1:0]    key;
   logic             present, has_free, hit_mark;
   logic [ROW_W-1:0] new_row;
   status_type       status;

   // power-of-two bucket count: the bucket is the key's low bits
   assign bucket = head.key[IDX_W-1:0];
   assign key    = head.key[KW-1:0];

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         vld[w] = rd_row_ff[w*EW + EW - 1];
         mk[w]  = rd_row_ff[w*EW];
         hit[w] = rd_row_ff[w*EW + EW - 1] && (rd_row_ff[w*EW + 1 +: KW] == key);
      end
      free       = ~vld;
      first_hit  = hit & (~hit + 1'b1);
      first_free = free & (~free + 1'b1);
      present    = |hit;
      has_free   = |free;
      hit_mark   = |(first_hit & mk);
   end

   always_comb begin
      new_row = rd_row_ff;
      status  = ST_OK;
      unique case (head.op)
         OP_INSERT: begin
            if (present) begin
               status = ST_PRESENT;
            end else if (!has_free) begin
               status = ST_FULL;
            end
            for (int w = 0; w < WAYS; w++) begin
               if (!present && first_free[w]) begin
                  new_row[w*EW +: EW] = {1'b1, key, head.temperature};
               end
            end
         end
         OP_FIND: begin
            if (!present) status = ST_NOT_FOUND;
         end
         OP_REMOVE: begin
            if (!present) status = ST_NOT_FOUND;
            for (int w = 0; w < WAYS; w++) begin
               if (first_hit[w]) new_row[w*EW + EW - 1] = 1'b0;
            end
         end
         OP_REPLACE: begin
            if (!present) status = ST_NOT_FOUND;
            for (int w = 0; w < WAYS; w++) begin
               if (hit[w]) new_row[w*EW] = head.temperature;
            end
         end
         default: status = ST_OK;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = bucket;
      wr_data = new_row;
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (state_ff == S_EXEC) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_row_ff <= mem[bucket];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == IDX_W'(BUCKETS - 1)) state_ff <= S_READ;
            end
            S_READ: begin
               if (head.valid) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               rsp_valid_ff  <= 1'b1;
               rsp_found_ff  <= present;
               rsp_temp_ff   <= (head.op == OP_FIND) && hit_mark;
               rsp_status_ff <= status;
               state_ff      <= S_READ;
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   assign back_stat.clearing  = (state_ff == S_CLEAR);
   assign back_stat.pop       = (state_ff == S_EXEC);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_temperature_out = rsp_temp_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

[hw/rtl/block_temperature_hash_table.sv]
// Hot/cold mark table keyed by flash block number, BUCKETS buckets of WAYS ways.
// Request channel: drive req_operation, req_block_number and req_temperature
// with start high; the request is taken on a rising edge where busy is low.
// Operations: insert, find, remove, replace mark. Each request gives exactly
// one response, in request order.
// Response channel: rsp_valid is high for one cycle with rsp_found,
// rsp_temperature_out and rsp_status; the receiver cannot stall it.
// Each request passes through the back end's read state (the bucket row is
// read into a register) and its execute state (compare, write back and
// register the response); the back end finishes the read-modify-write of one
// bucket row before it takes the next request.
// A 2-entry request queue lets a few requests be taken while the back end
// works; busy stays high while that queue is full.
// Reset: synchronous, active high. After reset the table is swept clear one
// bucket row a cycle, all BUCKETS rows (512 by default), with busy held high.
// BUCKETS must be a power of two.
module block_temperature_hash_table #(
   parameter int BUCKETS  = 512,
   parameter int WAYS     = 4,
   parameter int KEY_BITS = 31
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_operation,
   input  logic [bth_pkg::BLOCK_NUMBER_W-1:0] req_block_number,
   input  logic                               req_temperature,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic                               rsp_temperature_out,
   output logic [1:0]                         rsp_status
);
   import bth_pkg::*;

   cmd_type       head;
   back_stat_type back_stat;

   bth_front #(
      .KEY_BITS(KEY_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_operation   (req_operation),
      .req_block_number(req_block_number),
      .req_temperature (req_temperature),
      .back_stat       (back_stat),
      .busy            (busy),
      .head            (head)
   );

   bth_back #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS),
      .KEY_BITS(KEY_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .back_stat          (back_stat),
      .rsp_valid          (rsp_valid),
      .rsp_found          (rsp_found),
      .rsp_temperature_out(rsp_temperature_out),
      .rsp_status         (rsp_status)
   );

`include "assert_macros.svh"

   `ASSERT_NEXT(a_rsp_spaced, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_NEXT(a_pop_gives_rsp, clock, reset, back_stat.pop, rsp_valid)
   `ASSERT_IMPLY(a_no_rsp_in_clear, clock, reset, back_stat.clearing, !rsp_valid && busy)

endmodule
